/* hdl/fhcs_pkg.sv */
// Shared constants, codes and controller/datapath bundles for the first-hit collider search.
package fhcs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // field widths
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int POS_W   = 16;
  localparam int LEN_W   = 15;
  localparam int HIDX_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // table entry layouts: circle {x, y, r}, rectangle {x, y, w, h}
  localparam int CIRC_W = 2 * POS_W + LEN_W;
  localparam int RECT_W = 2 * POS_W + 2 * LEN_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WR_CIRC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_RECT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QRY_CIRC = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QRY_RECT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_COUNT   = 1'b1;

  typedef struct packed {
    logic             clear;      // drop previous search result
    logic             start;      // latch query circle and table select
    logic             kind_rect;  // query targets rectangle table
    logic             wr_circ;
    logic             wr_rect;
    logic             rd;         // issue one table read
    logic [IDX_W-1:0] rd_addr;
    logic             load_out;   // move search result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic found;  // an overlap has been recorded
    logic busy;   // reads still in the compare pipeline
  } dp_status_t;

endpackage

/* hdl/fhcs_if.sv */
// Channel interfaces: request items, result items and configuration writes.
interface fhcs_req_if;
  logic                           valid;
  logic                           ready;
  logic [fhcs_pkg::ACT_W-1:0]     action;
  logic [fhcs_pkg::SLOT_W-1:0]    entry_index;
  logic signed [fhcs_pkg::POS_W-1:0] pos_x;
  logic signed [fhcs_pkg::POS_W-1:0] pos_y;
  logic [fhcs_pkg::LEN_W-1:0]     radius;
  logic [fhcs_pkg::LEN_W-1:0]     width;
  logic [fhcs_pkg::LEN_W-1:0]     height;

  modport source(output valid, action, entry_index, pos_x, pos_y, radius, width, height,
                 input ready);
  modport sink(input valid, action, entry_index, pos_x, pos_y, radius, width, height,
               output ready);
endinterface

interface fhcs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [fhcs_pkg::HIDX_W-1:0]  hit_index;

  modport source(output valid, hit, hit_index, input ready);
  modport sink(input valid, hit, hit_index, output ready);
endinterface

interface fhcs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fhcs_pkg::CFG_IDX_W-1:0]   index;
  logic [fhcs_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/fhcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fhcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fhcs_ctrl.sv */
// Controller: count registers, item sequencing, scan address counter, result handshake.
module fhcs_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [fhcs_pkg::ACT_W-1:0]          action,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fhcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fhcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  input  fhcs_pkg::dp_status_t                st,
  output fhcs_pkg::ctrl_cmd_t                 cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state, state_next;
  logic [fhcs_pkg::CNT_W-1:0]      circle_count, rect_count;
  logic [fhcs_pkg::CNT_W-1:0]      scan_len, scan_len_next;
  logic [fhcs_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            rsp_valid_next;
  logic                            accept;
  logic                            out_free;
  logic [fhcs_pkg::CNT_W-1:0]      sel_count;
  logic [fhcs_pkg::CNT_W-1:0]      clamp_count;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_count <= '0;
      rect_count   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fhcs_pkg::REG_CIRCLE_COUNT: circle_count <= cfg_data;
        fhcs_pkg::REG_RECT_COUNT:   rect_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sel_count = (action == fhcs_pkg::ACT_QRY_RECT) ? rect_count : circle_count;
  assign clamp_count = (sel_count > fhcs_pkg::CNT_W'(fhcs_pkg::MAX_ENTRIES))
                     ? fhcs_pkg::CNT_W'(fhcs_pkg::MAX_ENTRIES) : sel_count;

  always_comb begin
    state_next     = state;
    scan_len_next  = scan_len;
    cnt_next       = cnt;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd            = '0;
    cmd.rd_addr    = cnt[fhcs_pkg::IDX_W-1:0];
    cmd.kind_rect  = (action == fhcs_pkg::ACT_QRY_RECT);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.clear = 1'b1;
          unique case (action)
            fhcs_pkg::ACT_WR_CIRC: begin
              cmd.wr_circ = 1'b1;
              state_next  = ST_DONE;
            end
            fhcs_pkg::ACT_WR_RECT: begin
              cmd.wr_rect = 1'b1;
              state_next  = ST_DONE;
            end
            default: begin
              cmd.start     = 1'b1;
              scan_len_next = clamp_count;
              cnt_next      = '0;
              state_next    = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd = (cnt < scan_len) && !st.found;
        if (cmd.rd) begin
          cnt_next = cnt + fhcs_pkg::CNT_W'(1);
        end else if (!st.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      scan_len  <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      cnt       <= cnt_next;
      scan_len  <= scan_len_next;
    end
  end

endmodule

/* hdl/fhcs_dp.sv */
// Datapath: entry tables, query registers, overlap compare pipeline, first-hit capture.
module fhcs_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fhcs_pkg::ctrl_cmd_t                   cmd,
  output fhcs_pkg::dp_status_t                  st,
  input  logic [fhcs_pkg::SLOT_W-1:0]           entry_index,
  input  logic signed [fhcs_pkg::POS_W-1:0]     pos_x,
  input  logic signed [fhcs_pkg::POS_W-1:0]     pos_y,
  input  logic [fhcs_pkg::LEN_W-1:0]            radius,
  input  logic [fhcs_pkg::LEN_W-1:0]            width,
  input  logic [fhcs_pkg::LEN_W-1:0]            height,
  output logic                                  hit,
  output logic [fhcs_pkg::HIDX_W-1:0]           hit_index
);

  localparam int PW = fhcs_pkg::POS_W;
  localparam int LW = fhcs_pkg::LEN_W;
  localparam int IW = fhcs_pkg::IDX_W;

  logic [fhcs_pkg::CIRC_W-1:0] circ_rd;
  logic [fhcs_pkg::RECT_W-1:0] rect_rd;

  fhcs_ram #(.WIDTH(fhcs_pkg::CIRC_W), .DEPTH(fhcs_pkg::MAX_ENTRIES)) u_circ_ram (
    .clk   (clk),
    .we    (cmd.wr_circ),
    .waddr (entry_index[IW-1:0]),
    .wdata ({pos_x, pos_y, radius}),
    .raddr (cmd.rd_addr),
    .rdata (circ_rd)
  );

  fhcs_ram #(.WIDTH(fhcs_pkg::RECT_W), .DEPTH(fhcs_pkg::MAX_ENTRIES)) u_rect_ram (
    .clk   (clk),
    .we    (cmd.wr_rect),
    .waddr (entry_index[IW-1:0]),
    .wdata ({pos_x, pos_y, width, height}),
    .raddr (cmd.rd_addr),
    .rdata (rect_rd)
  );

  // query circle
  logic signed [PW-1:0] q_x, q_y;
  logic [LW-1:0]        q_r;
  logic                 kind_rect;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_x       <= pos_x;
      q_y       <= pos_y;
      q_r       <= radius;
      kind_rect <= cmd.kind_rect;
    end
  end

  // stage 0: table data out of RAM
  logic signed [PW-1:0] e_x, e_y, b_x, b_y;
  logic [LW-1:0]        e_r, b_w, b_h;
  logic signed [PW:0]   dx, dy;
  logic [LW:0]          rs;
  logic signed [PW:0]   q_lo_x, q_hi_x, q_lo_y, q_hi_y, b_hi_x, b_hi_y;
  logic                 box;

  assign e_x = circ_rd[2*PW+LW-1 -: PW];
  assign e_y = circ_rd[PW+LW-1 -: PW];
  assign e_r = circ_rd[LW-1:0];
  assign b_x = rect_rd[2*PW+2*LW-1 -: PW];
  assign b_y = rect_rd[PW+2*LW-1 -: PW];
  assign b_w = rect_rd[2*LW-1 -: LW];
  assign b_h = rect_rd[LW-1:0];

  assign dx = {q_x[PW-1], q_x} - {e_x[PW-1], e_x};
  assign dy = {q_y[PW-1], q_y} - {e_y[PW-1], e_y};
  assign rs = {1'b0, q_r} + {1'b0, e_r};

  // circle bounding box against rectangle, strict on all four sides
  assign q_hi_x = {q_x[PW-1], q_x} + {2'b00, q_r};
  assign q_lo_x = {q_x[PW-1], q_x} - {2'b00, q_r};
  assign q_hi_y = {q_y[PW-1], q_y} + {2'b00, q_r};
  assign q_lo_y = {q_y[PW-1], q_y} - {2'b00, q_r};
  assign b_hi_x = {b_x[PW-1], b_x} + {2'b00, b_w};
  assign b_hi_y = {b_y[PW-1], b_y} + {2'b00, b_h};
  assign box = (q_hi_x > $signed({b_x[PW-1], b_x})) && (q_hi_y > $signed({b_y[PW-1], b_y}))
            && (q_lo_x < b_hi_x) && (q_lo_y < b_hi_y);

  // pipeline control
  logic          rd_v, s1_v, s2_v;
  logic [IW-1:0] idx0, idx1, idx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd;
      s1_v <= rd_v;
      s2_v <= s1_v;
    end
  end

  // stage 1: differences and box result
  logic signed [PW:0] s1_dx, s1_dy;
  logic [LW:0]        s1_rs;
  logic               s1_box;

  always_ff @(posedge clk) begin
    idx0   <= cmd.rd_addr;
    idx1   <= idx0;
    idx2   <= idx1;
    s1_dx  <= dx;
    s1_dy  <= dy;
    s1_rs  <= rs;
    s1_box <= box;
  end

  // stage 2: squares
  logic [2*PW+1:0] s2_dx2, s2_dy2;
  logic [2*LW+1:0] s2_rs2;
  logic            s2_box;

  always_ff @(posedge clk) begin
    s2_dx2 <= (2*PW+2)'(s1_dx * s1_dx);
    s2_dy2 <= (2*PW+2)'(s1_dy * s1_dy);
    s2_rs2 <= (2*LW+2)'(s1_rs * s1_rs);
    s2_box <= s1_box;
  end

  logic [2*PW+2:0] dist2;
  logic            hit2;

  assign dist2 = {1'b0, s2_dx2} + {1'b0, s2_dy2};
  assign hit2  = kind_rect ? s2_box : (dist2 < (2*PW+3)'(s2_rs2));

  // first hit capture; reads are issued in index order
  logic          found;
  logic [IW-1:0] found_idx;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      found     <= 1'b0;
      found_idx <= '0;
    end else if (s2_v && hit2 && !found) begin
      found     <= 1'b1;
      found_idx <= idx2;
    end
  end

  assign st.found = found;
  assign st.busy  = rd_v || s1_v || s2_v;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit       <= found;
      hit_index <= fhcs_pkg::HIDX_W'(found_idx);
    end
  end

endmodule

/* hdl/first_hit_collider_search.sv */
// Top level of the first-hit collider search: channels, controller and datapath.
//
// The block keeps a 64-entry circle table and a 64-entry rectangle table in RAM and
// answers one transaction on rsp for every transaction taken on req. Table writes
// (action 0 and 1) store the entry at the accepting edge and return hit = 0,
// hit_index = 0. A query (action 2 circles, 3 rectangles) scans the active
// entries of one table in index order, one RAM read per cycle, through a
// three-stage compare pipeline (RAM read, differences/box test, squares), and
// stops issuing reads once the first overlap is recorded. A miss reads all n
// active entries, where n is the active count clamped to 64, and a hit ends the
// scan sooner when an early entry overlaps; the single RAM read port per table
// sets the pace of the scan. One item is worked on at a time; req stays ready
// whenever no item is in progress, even while a result waits in the output
// register. circle_count and rect_count reset to 0 and are written on cfg,
// which is always ready; write them only while the block is idle.
// Table entries below the active count must be written before a query reads them.
module first_hit_collider_search (
  input logic         clk,
  input logic         rst,
  fhcs_req_if.sink    req,
  fhcs_rsp_if.source  rsp,
  fhcs_cfg_if.sink    cfg
);

  fhcs_pkg::ctrl_cmd_t  cmd;
  fhcs_pkg::dp_status_t st;

  // sequencing, count registers and rsp valid
  fhcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .action    (req.action),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // tables, compare pipeline and result register
  fhcs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .entry_index (req.entry_index),
    .pos_x       (req.pos_x),
    .pos_y       (req.pos_y),
    .radius      (req.radius),
    .width       (req.width),
    .height      (req.height),
    .hit         (rsp.hit),
    .hit_index   (rsp.hit_index)
  );

endmodule

/* test/tb_first_hit_collider_search.sv */
// Self-checking testbench for first_hit_collider_search: table writes, queries, count registers.
module tb_first_hit_collider_search;
  import fhcs_pkg::*;

  // One request transaction as the testbench sees it.
  typedef struct {
    bit [ACT_W-1:0]        action;
    bit [SLOT_W-1:0]       slot;
    bit signed [POS_W-1:0] x;
    bit signed [POS_W-1:0] y;
    bit [LEN_W-1:0]        r;
    bit [LEN_W-1:0]        w;
    bit [LEN_W-1:0]        h;
  } shape_req_t;

  typedef struct {
    bit               hit;
    bit [HIDX_W-1:0]  index;
  } hit_answer_t;

  typedef struct {
    bit signed [POS_W-1:0] x;
    bit signed [POS_W-1:0] y;
    bit [LEN_W-1:0]        r;
  } circle_t;

  typedef struct {
    bit signed [POS_W-1:0] x;
    bit signed [POS_W-1:0] y;
    bit [LEN_W-1:0]        w;
    bit [LEN_W-1:0]        h;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fhcs_req_if req_ch();
  fhcs_rsp_if rsp_ch();
  fhcs_cfg_if cfg_ch();

  first_hit_collider_search u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block state: both tables and both count registers.
  circle_t              circle_shadow [MAX_ENTRIES];
  box_t                 box_shadow    [MAX_ENTRIES];
  bit [CFG_DATA_W-1:0]  circle_count_q;
  bit [CFG_DATA_W-1:0]  rect_count_q;

  // Answers owed by the block, oldest first.
  hit_answer_t pending_answers [$];

  // Idle knobs, in percent of cycles.
  int send_idle_pct;
  int stall_pct;
  int error_count;

  // Applies one request to the shadow state and returns the answer the block owes.
  function automatic hit_answer_t predict_answer(input shape_req_t it);
    hit_answer_t ans;
    int          n;
    longint      dx;
    longint      dy;
    longint      rs;
    longint      cx;
    longint      cy;
    longint      cr;
    ans.hit   = 1'b0;
    ans.index = '0;
    cx = longint'(it.x);
    cy = longint'(it.y);
    cr = longint'(it.r);
    case (it.action)
      ACT_WR_CIRC: begin
        circle_shadow[it.slot] = '{x: it.x, y: it.y, r: it.r};
      end
      ACT_WR_RECT: begin
        box_shadow[it.slot] = '{x: it.x, y: it.y, w: it.w, h: it.h};
      end
      ACT_QRY_CIRC: begin
        // counts above the table size clamp to the table size
        n = (circle_count_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(circle_count_q);
        for (int i = 0; i < n; i++) begin
          dx = cx - longint'(circle_shadow[i].x);
          dy = cy - longint'(circle_shadow[i].y);
          rs = cr + longint'(circle_shadow[i].r);
          // strict: tangent circles do not overlap
          if (!ans.hit && (dx * dx + dy * dy < rs * rs)) begin
            ans.hit   = 1'b1;
            ans.index = HIDX_W'(i);
          end
        end
      end
      default: begin
        n = (rect_count_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(rect_count_q);
        for (int i = 0; i < n; i++) begin
          // bounding box of the query against [x, x+w] x [y, y+h], edges excluded
          if (!ans.hit
              && (cx + cr > longint'(box_shadow[i].x))
              && (cy + cr > longint'(box_shadow[i].y))
              && (cx - cr < longint'(box_shadow[i].x) + longint'(box_shadow[i].w))
              && (cy - cr < longint'(box_shadow[i].y) + longint'(box_shadow[i].h))) begin
            ans.hit   = 1'b1;
            ans.index = HIDX_W'(i);
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic shape_req_t shape_item(input bit [ACT_W-1:0] act, input int slot,
                                            input int x, input int y, input int r,
                                            input int w, input int h);
    shape_req_t it;
    it.action = act;
    it.slot   = SLOT_W'(slot);
    it.x      = POS_W'(x);
    it.y      = POS_W'(y);
    it.r      = LEN_W'(r);
    it.w      = LEN_W'(w);
    it.h      = LEN_W'(h);
    return it;
  endfunction

  // Mix of wide scatter, a cluster near the origin, and the corners of the range.
  function automatic int random_coord();
    case ($urandom_range(3))
      0, 1:    return int'($urandom_range(65535)) - 32768;
      2:       return int'($urandom_range(2047)) - 1024;
      default: begin
        case ($urandom_range(3))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic int random_length();
    case ($urandom_range(3))
      0:       return $urandom_range(63);
      1:       return $urandom_range(1023);
      2:       return $urandom_range(32767);
      default: return $urandom_range(1) ? 32767 : 0;
    endcase
  endfunction

  // Unused fields still carry random content; the block must ignore them.
  function automatic shape_req_t random_item(input bit [ACT_W-1:0] act);
    return shape_item(act, $urandom_range(63), random_coord(), random_coord(),
                      random_length(), random_length(), random_length());
  endfunction

  function automatic bit [ACT_W-1:0] random_action();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15)      return ACT_WR_CIRC;
    else if (pick < 30) return ACT_WR_RECT;
    else if (pick < 65) return ACT_QRY_CIRC;
    else                return ACT_QRY_RECT;
  endfunction

  function automatic bit [CFG_DATA_W-1:0] count_choice();
    case ($urandom_range(6))
      0:       return 0;
      1:       return 1;
      2:       return 63;
      3:       return 64;
      4:       return 65;
      5:       return 127;
      default: return $urandom_range(127);
    endcase
  endfunction

  // Sends one request transaction; valid stays high when the next one follows at once.
  task automatic send_item(input shape_req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= it.action;
    req_ch.entry_index <= it.slot;
    req_ch.pos_x       <= it.x;
    req_ch.pos_y       <= it.y;
    req_ch.radius      <= it.r;
    req_ch.width       <= it.w;
    req_ch.height      <= it.h;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_answers.push_back(predict_answer(it));
  endtask

  // Counts change only with the block idle: drain every answer first.
  task automatic set_counts(input bit [CFG_DATA_W-1:0] circles,
                            input bit [CFG_DATA_W-1:0] rects);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_CIRCLE_COUNT;
    cfg_ch.data  <= circles;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    circle_count_q = circles;
    cfg_ch.index <= REG_RECT_COUNT;
    cfg_ch.data  <= rects;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    rect_count_q = rects;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Result checker and receiver stall in one process: the check uses the
  // ready value that was in force at this edge.
  always @(posedge clk) begin
    hit_answer_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report($sformatf("result with nothing pending: hit %b index %0d",
                         rsp_ch.hit, rsp_ch.hit_index));
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.hit !== want.hit)
          report($sformatf("hit: expected %b, got %b", want.hit, rsp_ch.hit));
        if (rsp_ch.hit_index !== want.index)
          report($sformatf("hit_index: expected %0d, got %0d", want.index, rsp_ch.hit_index));
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Counts are zero after reset, so every query must miss.
  task automatic test_empty_tables();
    send_item(shape_item(ACT_QRY_CIRC, 63, -32768, 32767, 32767, 32767, 32767));
    send_item(shape_item(ACT_QRY_RECT, 0, 32767, -32768, 32767, 0, 0));
  endtask

  // Touching cases, extreme coordinates and full-width sums on slots 0 and 1.
  task automatic test_edge_contacts();
    send_item(shape_item(ACT_WR_CIRC, 0, 0, 0, 0, 32767, 32767));
    send_item(shape_item(ACT_WR_RECT, 0, -32768, -32768, 12345, 32767, 32767));
    send_item(shape_item(ACT_WR_CIRC, 1, 32767, 32767, 32767, 0, 21845));
    send_item(shape_item(ACT_WR_RECT, 1, 32767, 32767, 32767, 0, 0));
    set_counts(1, 1);
    // zero radii at the same point: distance 0 is not below 0
    send_item(shape_item(ACT_QRY_CIRC, 5, 0, 0, 0, 0, 0));
    send_item(shape_item(ACT_QRY_CIRC, 0, 0, 16, 16, 0, 0));   // tangent
    send_item(shape_item(ACT_QRY_CIRC, 0, 0, 16, 17, 0, 0));   // just inside
    // box 0 spans -32768..-1 on both axes
    send_item(shape_item(ACT_QRY_RECT, 0, 0, 0, 0, 0, 0));
    send_item(shape_item(ACT_QRY_RECT, 0, -1, -1, 0, 0, 0));   // on the far edge
    send_item(shape_item(ACT_QRY_RECT, 0, -2, -2, 0, 0, 0));
    send_item(shape_item(ACT_QRY_RECT, 0, 0, 0, 2, 0, 0));
    send_item(shape_item(ACT_QRY_RECT, 0, -32768, -32768, 0, 0, 0)); // on the near edge
    set_counts(2, 2);
    // farthest apart with largest radii: squares need full width
    send_item(shape_item(ACT_QRY_CIRC, 0, -32768, -32768, 32767, 0, 0));
    send_item(shape_item(ACT_QRY_CIRC, 0, 16384, 16384, 16384, 0, 0)); // misses 0, hits 1
    send_item(shape_item(ACT_QRY_RECT, 0, 32767, 32767, 1, 0, 0));     // zero-size box 1
    send_item(shape_item(ACT_QRY_RECT, 0, 32767, 32767, 0, 0, 0));
  endtask

  // Writes every remaining slot so that any count is safe to search.
  task automatic test_fill_tables();
    shape_req_t it;
    for (int s = 2; s < MAX_ENTRIES; s++) begin
      it = random_item(ACT_WR_CIRC);
      it.slot = SLOT_W'(s);
      send_item(it);
      it = random_item(ACT_WR_RECT);
      it.slot = SLOT_W'(s);
      send_item(it);
    end
    // full tables, then counts beyond the table size
    set_counts(64, 127);
    for (int k = 0; k < 4; k++) send_item(random_item(k[0] ? ACT_QRY_RECT : ACT_QRY_CIRC));
    set_counts(127, 64);
    for (int k = 0; k < 4; k++) send_item(random_item(k[0] ? ACT_QRY_RECT : ACT_QRY_CIRC));
  endtask

  // Mixed writes and queries under a few count settings.
  task automatic test_random_traffic(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int k = 0; k < 3; k++) begin
      set_counts(count_choice(), count_choice());
      for (int j = 0; j < 75; j++) send_item(random_item(random_action()));
    end
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_WR_CIRC;
    req_ch.entry_index = '0;
    req_ch.pos_x       = '0;
    req_ch.pos_y       = '0;
    req_ch.radius      = '0;
    req_ch.width       = '0;
    req_ch.height      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_CIRCLE_COUNT;
    cfg_ch.data        = '0;
    rsp_ch.ready       = 1'b0;
    circle_count_q     = '0;
    rect_count_q       = '0;
    error_count        = 0;
    send_idle_pct      = 16;
    stall_pct          = 86;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_tables();
    test_edge_contacts();
    test_fill_tables();
    test_random_traffic(16, 86);
    test_random_traffic(86, 16);
    test_random_traffic(0, 0);

    // drain, then leave room for any stray result
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("first_hit_collider_search regression: pass");
    else
      $display("first_hit_collider_search regression: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("first_hit_collider_search regression: fail");
    $finish;
  end

endmodule
